// ===== rtl/core/u2u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 converter.
package u2u8_pkg;

   localparam int NAME_LIMIT  = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_LONG = 2'd2
   } status_type;

   typedef enum logic {
      REG_LITTLE_ENDIAN = 1'b0,
      REG_CAPACITY      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        little_endian;
      logic [15:0] capacity;
   } cfg_type;

   // One queued word: up to four data bytes, then an optional terminator.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      logic            term;
      status_type      status;
      logic [7:0]      count;
   } entry_type;

endpackage

// ===== rtl/core/utf16_to_utf8_converter.sv =====
// UTF-16 to UTF-8 converter top level: configuration registers and block wiring.
//
// Input channel (req_): one 16-bit code unit per word plus last_unit on the
// final unit of a string. Bytes are swapped when little_endian is 0.
// Output channel (rsp_): one UTF-8 byte per word; a string closes with a
// terminator word (out_byte 0, end_of_string 1) carrying status and byte_count.
// last_of_run marks the final output word caused by one input word.
// Configuration: APB-style port, little_endian at 0x0, capacity at 0x4.
// Path: an accepted unit is encoded combinationally, written into the queue, then loaded into the output register.
// Throughput: the back end sends one output word per cycle unless rsp_stall holds it;
// a unit yields 1 to 5 words, and units that are dropped or held as a high surrogate yield none.
// A two-word queue lets the front accept while the back end drains.
// Reset: synchronous, clears the queue, surrogate and count state, and sets
// little_endian to 1 and capacity to 256.
// Stall: rsp_stall holds the output word; the queue fills and then req_stall
// rises until space frees.
module utf16_to_utf8_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_string,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_byte_count,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import u2u8_pkg::*;

   logic          le_ff, le_in;
   logic [15:0]   cap_ff, cap_in;
   cfg_type       cfg;
   reg_index_type reg_sel;
   logic          wr_en;

   logic      in_accept, q_push, q_pop, q_full, q_empty;
   entry_type q_entry, q_head;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      le_in  = le_ff;
      cap_in = cap_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LITTLE_ENDIAN: le_in  = pwdata[0];
            REG_CAPACITY:      cap_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LITTLE_ENDIAN: prdata = {31'd0, le_ff};
         REG_CAPACITY:      prdata = {16'd0, cap_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         le_ff  <= 1'b1;
         cap_ff <= 16'd256;
      end else begin
         le_ff  <= le_in;
         cap_ff <= cap_in;
      end
   end

   assign cfg.little_endian = le_ff;
   assign cfg.capacity      = cap_ff;

   assign req_stall = q_full;
   assign in_accept = req_valid && !req_stall;

   u2u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_accept (in_accept),
      .code_unit (req_code_unit),
      .last_unit (req_last_unit),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   u2u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   u2u8_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_status        (rsp_status),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== rtl/core/u2u8_front.sv =====
// Front end: byte order, surrogate pairing, length check and UTF-8 encoding.
module u2u8_front (
   input  logic                clock,
   input  logic                reset,
   input  u2u8_pkg::cfg_type   cfg,
   input  logic                in_accept,
   input  logic [15:0]         code_unit,
   input  logic                last_unit,
   output logic                q_push,
   output u2u8_pkg::entry_type q_entry
);
   import u2u8_pkg::*;

   logic [9:0]  pend_bits_ff, pend_bits_in;
   logic        pend_ff, pend_in;
   logic [7:0]  emitted_ff, emitted_in;
   logic        discard_ff, discard_in;

   logic [15:0] unit_sw;
   logic        is_low, is_high;
   logic [20:0] cp;
   logic [2:0]  len;
   logic [15:0] limit, need;
   logic [7:0]  emitted_new;

   assign unit_sw = cfg.little_endian ? code_unit : {code_unit[7:0], code_unit[15:8]};
   assign is_low  = (unit_sw[15:10] == 6'b110111);
   assign is_high = (unit_sw[15:10] == 6'b110110);
   assign cp = pend_ff ? (21'({pend_bits_ff, unit_sw[9:0]}) + 21'h10000) : 21'(unit_sw);

   always_comb begin
      if (cp < 21'h80) begin
         len = 3'd1;
      end else if (cp < 21'h800) begin
         len = 3'd2;
      end else if (cp < 21'h10000) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
   end

   assign limit       = (cfg.capacity < 16'(NAME_LIMIT)) ? cfg.capacity : 16'(NAME_LIMIT);
   assign need        = 16'(emitted_ff) + 16'(len);
   assign emitted_new = emitted_ff + 8'(len);

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_in      = pend_ff;
      emitted_in   = emitted_ff;
      discard_in   = discard_ff;
      q_push       = 1'b0;
      q_entry      = '0;
      q_entry.status = ST_OK;
      if (in_accept) begin
         if (discard_ff) begin
            if (last_unit) begin
               discard_in = 1'b0;
            end
         end else if ((cfg.capacity == 16'd0) || (pend_ff && !is_low) ||
                      (!pend_ff && is_low) || (!pend_ff && is_high && last_unit)) begin
            q_push         = 1'b1;
            q_entry.term   = 1'b1;
            q_entry.status = ST_BAD;
            q_entry.count  = emitted_ff;
            pend_in        = 1'b0;
            pend_bits_in   = '0;
            emitted_in     = '0;
            discard_in     = !last_unit;
         end else if (!pend_ff && is_high) begin
            pend_in      = 1'b1;
            pend_bits_in = unit_sw[9:0];
         end else if (need >= limit) begin
            q_push         = 1'b1;
            q_entry.term   = 1'b1;
            q_entry.status = ST_LONG;
            q_entry.count  = emitted_ff;
            pend_in        = 1'b0;
            pend_bits_in   = '0;
            emitted_in     = '0;
            discard_in     = !last_unit;
         end else begin
            q_push         = 1'b1;
            q_entry.nbytes = len;
            pend_in        = 1'b0;
            pend_bits_in   = '0;
            unique case (len)
               3'd1: q_entry.bytes[0] = cp[7:0];
               3'd2: begin
                  q_entry.bytes[0] = {3'b110, cp[10:6]};
                  q_entry.bytes[1] = {2'b10, cp[5:0]};
               end
               3'd3: begin
                  q_entry.bytes[0] = {4'b1110, cp[15:12]};
                  q_entry.bytes[1] = {2'b10, cp[11:6]};
                  q_entry.bytes[2] = {2'b10, cp[5:0]};
               end
               default: begin
                  q_entry.bytes[0] = {5'b11110, cp[20:18]};
                  q_entry.bytes[1] = {2'b10, cp[17:12]};
                  q_entry.bytes[2] = {2'b10, cp[11:6]};
                  q_entry.bytes[3] = {2'b10, cp[5:0]};
               end
            endcase
            if (last_unit) begin
               q_entry.term   = 1'b1;
               q_entry.status = ST_OK;
               q_entry.count  = emitted_new;
               emitted_in     = '0;
            end else begin
               emitted_in = emitted_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_ff      <= 1'b0;
         emitted_ff   <= '0;
         discard_ff   <= 1'b0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_ff      <= pend_in;
         emitted_ff   <= emitted_in;
         discard_ff   <= discard_in;
      end
   end

   a_no_pend_while_discard: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && discard_ff)) else $error("pending surrogate while discarding");

endmodule

// ===== rtl/core/u2u8_queue.sv =====
// Short queue of encoded words between front and back end.
module u2u8_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u2u8_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output u2u8_pkg::entry_type head
);
   import u2u8_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !do_pop) else $error("pop from empty queue");

endmodule

// ===== rtl/core/u2u8_back.sv =====
// Back end: steps through a queued word one byte per cycle into the output register, unless rsp_stall holds it.
module u2u8_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  u2u8_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_end_of_string,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_byte_count,
   output logic                rsp_last_of_run
);
   import u2u8_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       eos_ff, eos_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] count_ff, count_in;
   logic       lor_ff, lor_in;

   logic       advance, is_data, is_last;
   logic [2:0] total;

   assign advance = !valid_ff || !rsp_stall;
   assign total   = q_head.nbytes + 3'(q_head.term);
   assign is_data = (idx_ff < q_head.nbytes);
   assign is_last = (idx_ff == total - 3'd1);
   assign q_pop   = advance && !q_empty && is_last;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      eos_in    = eos_ff;
      status_in = status_ff;
      count_in  = count_ff;
      lor_in    = lor_ff;
      if (advance) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
            lor_in = is_last;
            if (is_data) begin
               byte_in   = q_head.bytes[idx_ff[1:0]];
               eos_in    = 1'b0;
               status_in = ST_OK;
               count_in  = '0;
            end else begin
               byte_in   = '0;
               eos_in    = 1'b1;
               status_in = q_head.status;
               count_in  = q_head.count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      eos_ff    <= eos_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      lor_ff    <= lor_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_status        = status_ff;
   assign rsp_byte_count    = count_ff;
   assign rsp_last_of_run   = lor_ff;

   a_idx_in_word: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (idx_ff < total)) else $error("byte index past end of word");
   a_eos_ends_run: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && eos_ff) |-> lor_ff) else $error("terminator not last of run");

endmodule

// ===== tb/utf16_to_utf8_converter_tb.sv =====
// Self-checking testbench for utf16_to_utf8_converter: directed and random strings, APB setup.
`timescale 1ns / 100ps

module utf16_to_utf8_converter_tb;
   import u2u8_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 80;
   localparam logic [5:0] HIGH_TAG = 6'b110110;
   localparam logic [5:0] LOW_TAG  = 6'b110111;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       eos;
      status_type status;
      logic [7:0] count;
      logic       run_end;
   } utf8_word_type;

   class utf8_scoreboard;
      bit          little_endian = 1'b1;
      logic [15:0] capacity = 16'd256;
      logic [9:0]  high_bits = '0;
      bit          high_held = 1'b0;
      logic [7:0]  emitted = '0;
      bit          dropping = 1'b0;
      utf8_word_type due[$];
      int unsigned mismatches = 0;
      int unsigned units_in = 0;
      int unsigned words_out = 0;
      int unsigned n_ok = 0;
      int unsigned n_bad = 0;
      int unsigned n_long = 0;

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_LITTLE_ENDIAN: little_endian = value[0];
            REG_CAPACITY:      capacity = value[15:0];
         endcase
      endfunction

      function void put_byte(logic [7:0] b);
         due.push_back(utf8_word_type'{b, 1'b0, ST_OK, 8'd0, 1'b0});
      endfunction

      function void close_string(status_type st, logic last);
         due.push_back(utf8_word_type'{8'd0, 1'b1, st, emitted, 1'b1});
         high_bits = '0;
         high_held = 1'b0;
         emitted = '0;
         dropping = !last;
      endfunction

      function void note_unit(logic [15:0] raw, logic last);
         logic [15:0] u;
         logic [20:0] cp;
         int len;
         int limit;
         units_in++;
         if (dropping) begin
            if (last) dropping = 1'b0;
            return;
         end
         if (capacity == 16'd0) begin
            close_string(ST_BAD, last);
            return;
         end
         u = little_endian ? raw : {raw[7:0], raw[15:8]};
         if (high_held) begin
            if (u[15:10] != LOW_TAG) begin
               close_string(ST_BAD, last);
               return;
            end
            cp = 21'({high_bits, u[9:0]});
            cp = cp + 21'h10000;
            high_held = 1'b0;
            high_bits = '0;
         end else if (u[15:10] == LOW_TAG) begin
            close_string(ST_BAD, last);
            return;
         end else if (u[15:10] == HIGH_TAG) begin
            if (last) begin
               close_string(ST_BAD, last);
               return;
            end
            high_bits = u[9:0];
            high_held = 1'b1;
            return;
         end else begin
            cp = 21'(u);
         end
         if (cp < 21'h80) len = 1;
         else if (cp < 21'h800) len = 2;
         else if (cp < 21'h10000) len = 3;
         else len = 4;
         limit = (capacity < NAME_LIMIT) ? capacity : NAME_LIMIT;
         if (emitted + len >= limit) begin
            close_string(ST_LONG, last);
            return;
         end
         case (len)
            1: put_byte(cp[7:0]);
            2: begin
               put_byte({3'b110, cp[10:6]});
               put_byte({2'b10, cp[5:0]});
            end
            3: begin
               put_byte({4'b1110, cp[15:12]});
               put_byte({2'b10, cp[11:6]});
               put_byte({2'b10, cp[5:0]});
            end
            default: begin
               put_byte({5'b11110, cp[20:18]});
               put_byte({2'b10, cp[17:12]});
               put_byte({2'b10, cp[11:6]});
               put_byte({2'b10, cp[5:0]});
            end
         endcase
         emitted = emitted + 8'(len);
         if (last) close_string(ST_OK, 1'b1);
         else due[due.size() - 1].run_end = 1'b1;
      endfunction

      function void check_word(utf8_word_type got);
         utf8_word_type want;
         words_out++;
         if (got.eos) begin
            case (got.status)
               ST_OK:   n_ok++;
               ST_BAD:  n_bad++;
               default: n_long++;
            endcase
         end
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: byte %02h eos %0b status %0d count %0d run_end %0b",
                        got.out_byte, got.eos, got.status, got.count, got.run_end);
            return;
         end
         want = due.pop_front();
         if (got.out_byte !== want.out_byte || got.eos !== want.eos ||
             got.status !== want.status || got.count !== want.count ||
             got.run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"word mismatch (byte/eos/status/count/run_end): ",
                         "got %02h/%0b/%0d/%0d/%0b, expected %02h/%0b/%0d/%0d/%0b"},
                        got.out_byte, got.eos, got.status, got.count, got.run_end,
                        want.out_byte, want.eos, want.status, want.count, want.run_end);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit = '0;
   logic        req_last_unit = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_string;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_byte_count;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   utf8_scoreboard sb;
   int send_idle_pct = 12;
   int rcv_idle_pct = 72;
   int units_sent = 0;
   int csr_writes = 0;
   int csr_errors = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_kick = 1'b0;
   bit hold_seen = 1'b0;

   utf16_to_utf8_converter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_code_unit(req_code_unit),
      .req_last_unit(req_last_unit),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_end_of_string(rsp_end_of_string),
      .rsp_status(rsp_status),
      .rsp_byte_count(rsp_byte_count),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_unit(req_code_unit, req_last_unit);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(utf8_word_type'{rsp_out_byte, rsp_end_of_string,
                                       status_type'(rsp_status),
                                       rsp_byte_count, rsp_last_of_run});
   end

   // receiver: random stall, or a long hold when kicked
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen = hold_kick;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [15:0] wide_bmp();
      return $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h800))
                               : 16'($urandom_range(16'hFFFF, 16'hE000));
   endfunction

   task automatic send_unit(input logic [15:0] code, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_unit <= code;
      req_last_unit <= last;
      do @(posedge clock); while (req_stall);
      units_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] want;
      want = (idx == REG_LITTLE_ENDIAN) ? {31'd0, value[0]} : {16'd0, value[15:0]};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
      csr_writes++;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         csr_errors++;
         $display("register readback at %0h: got %08h, expected %08h", {idx, 2'b00}, prdata,
                  want);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly well-formed text, some broken surrogates and raw noise
   task automatic send_string(input int n_units);
      logic [15:0] seq[$];
      int pick;
      while (seq.size() < n_units) begin
         pick = $urandom_range(99);
         if (pick < 20 && seq.size() + 1 < n_units) begin
            seq.push_back({HIGH_TAG, 10'($urandom)});
            seq.push_back({LOW_TAG, 10'($urandom)});
         end else if (pick < 26) begin
            seq.push_back(16'($urandom));
         end else if (pick < 29) begin
            seq.push_back({LOW_TAG, 10'($urandom)});
         end else if (pick < 32) begin
            seq.push_back({HIGH_TAG, 10'($urandom)});
         end else if (pick < 55) begin
            seq.push_back(16'($urandom_range(16'h7F)));
         end else if (pick < 75) begin
            seq.push_back(16'($urandom_range(16'h7FF, 16'h80)));
         end else begin
            seq.push_back(wide_bmp());
         end
      end
      foreach (seq[i])
         send_unit(sb.little_endian ? seq[i] : {seq[i][7:0], seq[i][15:8]}, i == seq.size() - 1);
   endtask

   task automatic run_block(input logic le, input logic [15:0] cap, input int n_units);
      int stop;
      settle();
      csr_write(REG_LITTLE_ENDIAN, 32'(le));
      csr_write(REG_CAPACITY, 32'(cap));
      stop = units_sent + n_units;
      while (units_sent < stop)
         send_string(($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1));
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_unit(16'h0000, 1'b0); send_unit(16'h007F, 1'b0); send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0); send_unit(16'h0800, 1'b0); send_unit(16'hFFFF, 1'b0);
      send_unit(16'hD800, 1'b0); send_unit(16'hDC00, 1'b0); send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      // lone low surrogate, rest of the string dropped
      send_unit(16'hDC00, 1'b0); send_unit(16'h0041, 1'b0); send_unit(16'h0042, 1'b1);
      send_unit(16'hD800, 1'b1);
      send_unit(16'hDBFF, 1'b0); send_unit(16'h0041, 1'b1);
      send_unit(16'hD800, 1'b0); send_unit(16'hD801, 1'b0); send_unit(16'h0043, 1'b1);
      // capacity shrinks mid-string
      send_unit(16'h0041, 1'b0);
      settle();
      csr_write(REG_CAPACITY, 2);
      send_unit(16'h0042, 1'b1);
      settle();
      csr_write(REG_LITTLE_ENDIAN, 0);
      csr_write(REG_CAPACITY, 0);
      send_unit(16'h4100, 1'b1);
      settle();
      csr_write(REG_CAPACITY, 32'hFFFF);
      send_unit(16'h4100, 1'b0); send_unit(16'h3DD8, 1'b0); send_unit(16'h00DE, 1'b1);

      run_block(1'b0, 16'hFFFF, 30);
      run_block(1'b1, 16'd1, 15);
      run_block(1'b0, 16'($urandom_range(48, 2)), 30);

      send_idle_pct = 72;
      rcv_idle_pct = 12;
      run_block(1'b1, 16'd256, 35);
      run_block(1'b1, 16'd257, 25);
      run_block(1'b0, 16'($urandom), 30);

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      run_block(1'b1, 16'hFFFF, 0);
      hold_kick <= ~hold_kick;
      for (int i = 0; i < 14; i++) send_unit(wide_bmp(), i == 13);
      settle();
      // runs into the name limit, tail dropped
      for (int i = 0; i < 95; i++) send_unit(wide_bmp(), i == 94);
      run_block(1'b0, 16'd3, 30);
      run_block(1'b1, 16'($urandom_range(300, 4)), 35);
      settle();

      $display("Sent %0d code units, checked %0d output words, %0d register writes.",
               sb.units_in, sb.words_out, csr_writes);
      $display("Strings closed: %0d ok, %0d bad value, %0d too long.",
               sb.n_ok, sb.n_bad, sb.n_long);
      if (sb.mismatches == 0 && csr_errors == 0 && sb.due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/u2u8_pkg.sv
rtl/core/u2u8_front.sv
rtl/core/u2u8_queue.sv
rtl/core/u2u8_back.sv
rtl/core/utf16_to_utf8_converter.sv
tb/utf16_to_utf8_converter_tb.sv
